// ===== sv/kvc_pkg.sv =====
// Shared constants, types and helper functions of the keyword violation counter.
package kvc_pkg;

   localparam int MAX_KEYWORDS    = 64;
   localparam int MAX_KEYWORD_LEN = 19;
   localparam int MAX_MSG_LEN     = 255;
   localparam int GROUP_COUNT     = 32;
   localparam int USER_COUNT      = 64;
   localparam int COUNTER_DEPTH   = GROUP_COUNT * USER_COUNT;

   localparam int BYTE_W      = 8;
   localparam int SLOT_W      = 6;
   localparam int POS_W       = 5;
   localparam int LEN_W       = 5;
   localparam int GROUP_W     = 5;
   localparam int USER_W      = 6;
   localparam int HITS_W      = 7;
   localparam int COUNT_W     = 16;
   localparam int ACT_W       = 7;
   localparam int SEEN_W      = 8;
   localparam int CNT_ADDR_W  = 11;
   localparam int REG_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCOUNT_W    = 3;
   localparam int PART_COUNT  = 8;
   localparam int PART_W      = 4;

   localparam logic [REG_INDEX_W-1:0] REG_VIOLATION_LIMIT = 2'd0;
   localparam logic [REG_INDEX_W-1:0] REG_ACTIVE_PATTERNS = 2'd1;

   localparam logic REQ_LOAD    = 1'b0;
   localparam logic REQ_MESSAGE = 1'b1;

   typedef struct packed {
      logic [GROUP_W-1:0]      sender_group;
      logic [USER_W-1:0]       user_id;
      logic [MAX_KEYWORDS-1:0] hit_vec;
   } job_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOK,
      ST_ADD,
      ST_PUT
   } back_state_type;

   function automatic logic [BYTE_W-1:0] fold(input logic [BYTE_W-1:0] c);
      if (c >= 8'h41 && c <= 8'h5A) begin
         return c + 8'h20;
      end
      return c;
   endfunction

endpackage

// ===== sv/kvc_req_if.sv =====
// Input channel interface of the keyword violation counter.
interface kvc_req_if import kvc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               req_type;
   logic [SLOT_W-1:0]  pattern_slot;
   logic [POS_W-1:0]   pattern_pos;
   logic [BYTE_W-1:0]  data_byte;
   logic               last_byte;
   logic [GROUP_W-1:0] sender_group;
   logic [USER_W-1:0]  user_id;

   modport source (output valid, req_type, pattern_slot, pattern_pos, data_byte, last_byte,
                   sender_group, user_id, input ready);
   modport sink (input valid, req_type, pattern_slot, pattern_pos, data_byte, last_byte,
                 sender_group, user_id, output ready);
endinterface

// ===== sv/kvc_rsp_if.sv =====
// Result channel interface of the keyword violation counter.
interface kvc_rsp_if import kvc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [GROUP_W-1:0] out_group;
   logic [USER_W-1:0]  out_user;
   logic [HITS_W-1:0]  message_hits;
   logic [COUNT_W-1:0] violation_total;
   logic               removed;

   modport source (output valid, out_group, out_user, message_hits, violation_total, removed,
                   input ready);
   modport sink (input valid, out_group, out_user, message_hits, violation_total, removed,
                 output ready);
endinterface

// ===== sv/kvc_csr_if.sv =====
// Configuration write channel interface of the keyword violation counter.
interface kvc_csr_if import kvc_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [REG_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/kvc_ram.sv =====
// Generic single-port-write, registered-read RAM.
module kvc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== sv/kvc_queue.sv =====
// Short queue of finished-message jobs between the matcher and the counter unit.
module kvc_queue import kvc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output job_type pop_job,
   output logic    empty,
   output logic    full
);
   job_type             slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCOUNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QPTR_W'(push);
      rd_ptr_in = rd_ptr_ff + QPTR_W'(pop);
      count_in  = count_ff + QCOUNT_W'(push) - QCOUNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign pop_job = slot_ff[rd_ptr_ff];
   assign empty   = (count_ff == '0);
   assign full    = (count_ff == QCOUNT_W'(QUEUE_DEPTH));
endmodule

// ===== sv/kvc_front.sv =====
// Front end: keyword table loading and per-byte matching against the message window.
module kvc_front import kvc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   kvc_req_if.sink          req,
   input  logic [ACT_W-1:0] active_patterns,
   input  logic             hold,
   output logic             push,
   output job_type          push_job
);
   logic [BYTE_W-1:0]       kw_ff [MAX_KEYWORDS][MAX_KEYWORD_LEN];
   logic [LEN_W-1:0]        len_ff [MAX_KEYWORDS];
   logic [BYTE_W-1:0]       recent_ff [MAX_KEYWORD_LEN-1];
   logic [SEEN_W-1:0]       seen_ff;
   logic                    ended_ff;
   logic [MAX_KEYWORDS-1:0] found_ff, found_in;

   logic                    accept;
   logic                    is_msg;
   logic                    take_byte;
   logic [BYTE_W-1:0]       win [MAX_KEYWORD_LEN];
   logic [MAX_KEYWORDS-1:0] match;
   logic [MAX_KEYWORDS-1:0] empty_kw;
   logic [MAX_KEYWORDS-1:0] act_mask;
   logic [ACT_W-1:0]        act;

   assign req.ready = !hold;
   assign accept    = req.valid && req.ready;
   assign is_msg    = (req.req_type == REQ_MESSAGE);
   assign take_byte = accept && is_msg && !ended_ff && (seen_ff != SEEN_W'(MAX_MSG_LEN))
                      && (req.data_byte != '0);

   always_comb begin
      win[0] = fold(req.data_byte);
      for (int i = 1; i < MAX_KEYWORD_LEN; i++) begin
         win[i] = recent_ff[i-1];
      end
   end

   always_comb begin
      act = (active_patterns > ACT_W'(MAX_KEYWORDS)) ? ACT_W'(MAX_KEYWORDS) : active_patterns;
      for (int s = 0; s < MAX_KEYWORDS; s++) begin
         act_mask[s] = (ACT_W'(s) < act);
      end
   end

   always_comb begin
      for (int s = 0; s < MAX_KEYWORDS; s++) begin
         logic [LEN_W-1:0] e;
         logic             ok;
         logic [LEN_W-1:0] k;
         e = len_ff[s];
         for (int j = MAX_KEYWORD_LEN - 1; j >= 0; j--) begin
            if (LEN_W'(j) < len_ff[s] && kw_ff[s][j] == '0) begin
               e = LEN_W'(j);
            end
         end
         ok = (e != '0);
         for (int j = 0; j < MAX_KEYWORD_LEN; j++) begin
            k = e - LEN_W'(1) - LEN_W'(j);
            if (LEN_W'(j) < e) begin
               if (fold(kw_ff[s][j]) != win[k]) begin
                  ok = 1'b0;
               end
            end
         end
         match[s]    = ok;
         empty_kw[s] = (e == '0);
      end
   end

   always_comb begin
      found_in = found_ff;
      if (take_byte) begin
         found_in = found_ff | (match & act_mask);
      end
   end

   assign push                  = accept && is_msg && req.last_byte;
   assign push_job.sender_group = req.sender_group;
   assign push_job.user_id      = req.user_id;
   assign push_job.hit_vec      = (found_in | empty_kw) & act_mask;

   always_ff @(posedge clock) begin
      if (accept && !is_msg && req.pattern_pos < POS_W'(MAX_KEYWORD_LEN)) begin
         kw_ff[req.pattern_slot][req.pattern_pos] <= req.data_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < MAX_KEYWORDS; s++) begin
            len_ff[s] <= '0;
         end
      end else if (accept && !is_msg && req.last_byte
                   && req.pattern_pos < POS_W'(MAX_KEYWORD_LEN)) begin
         len_ff[req.pattern_slot] <= req.pattern_pos + LEN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || push) begin
         for (int i = 0; i < MAX_KEYWORD_LEN - 1; i++) begin
            recent_ff[i] <= '0;
         end
         seen_ff  <= '0;
         ended_ff <= 1'b0;
         found_ff <= '0;
      end else begin
         found_ff <= found_in;
         if (take_byte) begin
            seen_ff <= seen_ff + SEEN_W'(1);
            for (int i = 0; i < MAX_KEYWORD_LEN - 1; i++) begin
               recent_ff[i] <= win[i];
            end
         end
         if (accept && is_msg && req.data_byte == '0) begin
            ended_ff <= 1'b1;
         end
      end
   end
endmodule

// ===== sv/kvc_back.sv =====
// Back end: counter memory clearing, saturating update and result register.
module kvc_back import kvc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_empty,
   input  job_type            q_job,
   output logic               q_pop,
   input  logic [COUNT_W-1:0] violation_limit,
   output logic               clearing,
   kvc_rsp_if.source          rsp
);
   back_state_type           state_ff, state_in;
   logic [CNT_ADDR_W-1:0]    clr_addr_ff;
   job_type                  job_ff;
   logic [PART_W-1:0]        part_ff [PART_COUNT];
   logic [HITS_W-1:0]        hits_ff;
   logic [COUNT_W-1:0]       total_ff;
   logic                     out_valid_ff;
   logic [GROUP_W-1:0]       out_group_ff;
   logic [USER_W-1:0]        out_user_ff;
   logic [HITS_W-1:0]        out_hits_ff;
   logic [COUNT_W-1:0]       out_total_ff;
   logic                     out_removed_ff;

   logic                     out_free;
   logic                     put_done;
   logic                     ram_wr_en;
   logic [CNT_ADDR_W-1:0]    ram_wr_addr;
   logic [COUNT_W-1:0]       ram_wr_data;
   logic [CNT_ADDR_W-1:0]    job_addr;
   logic [COUNT_W-1:0]       ram_rd_data;
   logic [HITS_W-1:0]        hits_sum;
   logic [COUNT_W:0]         total_wide;

   assign out_free = !out_valid_ff || rsp.ready;
   assign job_addr = {job_ff.sender_group, job_ff.user_id};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      q_pop       = 1'b0;
      put_done    = 1'b0;
      clearing    = 1'b0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = job_addr;
      ram_wr_data = total_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clearing    = 1'b1;
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_addr_ff;
            ram_wr_data = '0;
            if (clr_addr_ff == CNT_ADDR_W'(COUNTER_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            state_in = ST_ADD;
         end
         ST_ADD: begin
            state_in = ST_PUT;
         end
         ST_PUT: begin
            if (out_free) begin
               put_done  = 1'b1;
               ram_wr_en = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (state_ff == ST_CLEAR) begin
         clr_addr_ff <= clr_addr_ff + CNT_ADDR_W'(1);
      end
   end

   always_comb begin
      hits_sum = '0;
      for (int p = 0; p < PART_COUNT; p++) begin
         hits_sum = hits_sum + HITS_W'(part_ff[p]);
      end
      total_wide = {1'b0, ram_rd_data} + (COUNT_W + 1)'(hits_sum);
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         job_ff <= q_job;
      end
      if (state_ff == ST_LOOK) begin
         for (int p = 0; p < PART_COUNT; p++) begin
            part_ff[p] <= PART_W'($countones(job_ff.hit_vec[p*PART_COUNT +: PART_COUNT]));
         end
      end
      if (state_ff == ST_ADD) begin
         hits_ff  <= hits_sum;
         total_ff <= total_wide[COUNT_W] ? '1 : total_wide[COUNT_W-1:0];
      end
      if (put_done) begin
         out_group_ff   <= job_ff.sender_group;
         out_user_ff    <= job_ff.user_id;
         out_hits_ff    <= hits_ff;
         out_total_ff   <= total_ff;
         out_removed_ff <= (total_ff >= violation_limit);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (put_done) begin
         out_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   kvc_ram #(
      .WIDTH(COUNT_W),
      .DEPTH(COUNTER_DEPTH)
   ) u_counts (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (job_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp.valid           = out_valid_ff;
   assign rsp.out_group       = out_group_ff;
   assign rsp.out_user        = out_user_ff;
   assign rsp.message_hits    = out_hits_ff;
   assign rsp.violation_total = out_total_ff;
   assign rsp.removed         = out_removed_ff;

`ifndef SYNTHESIS
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty) else $error("Job taken from an empty queue.");
   a_no_result_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !out_valid_ff) else $error("Result shown during the clearing pass.");
   a_put_shows_result: assert property (@(posedge clock) disable iff (reset)
      put_done |=> out_valid_ff) else $error("Finished job did not reach the output.");
   a_total_not_below_hits: assert property (@(posedge clock) disable iff (reset)
      put_done |-> total_ff >= COUNT_W'(hits_ff)) else $error("Counter update lost hits.");
`endif
endmodule

// ===== sv/keyword_violation_counter_top.sv =====
// Top level of the keyword violation counter: config registers, matcher, queue and counter unit.
// Throughput: one input beat per cycle while the job queue has room and no clearing pass runs.
// A message's last byte queues a job; the counter unit does queue pop, memory read, add and
// write per job, takes the next job only after the write, and stalls the write (which loads
// the result register) while the output is busy. Reset is synchronous; a clearing pass then
// zeroes all 2048 counters; no input beat is taken meanwhile (configuration writes are).
module keyword_violation_counter_top import kvc_pkg::*; (
   input logic      clock,
   input logic      reset,
   kvc_req_if.sink  req,
   kvc_rsp_if.source rsp,
   kvc_csr_if.sink  csr
);
   logic [COUNT_W-1:0] limit_ff;
   logic [ACT_W-1:0]   active_ff;
   logic               push;
   job_type            push_job;
   logic               pop;
   job_type            pop_job;
   logic               q_empty;
   logic               q_full;
   logic               clearing;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff  <= COUNT_W'(1);
         active_ff <= '0;
      end else if (csr.valid) begin
         if (csr.index == REG_VIOLATION_LIMIT) begin
            limit_ff <= csr.data[COUNT_W-1:0];
         end else if (csr.index == REG_ACTIVE_PATTERNS) begin
            active_ff <= csr.data[ACT_W-1:0];
         end
      end
   end

   kvc_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req             (req),
      .active_patterns (active_ff),
      .hold            (q_full || clearing),
      .push            (push),
      .push_job        (push_job)
   );

   kvc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .pop_job  (pop_job),
      .empty    (q_empty),
      .full     (q_full)
   );

   kvc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_job           (pop_job),
      .q_pop           (pop),
      .violation_limit (limit_ff),
      .clearing        (clearing),
      .rsp             (rsp)
   );
endmodule

// ===== bench/tb_keyword_violation_counter_top.sv =====
// Testbench of the keyword violation counter: directed table, random traffic, scoreboard.
`timescale 1ns / 1ps

module tb_keyword_violation_counter_top;
   import kvc_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int SETTLE_WAIT  = 12;
   localparam int RANDOM_BEATS = 900;

   typedef enum logic {ROW_BEAT, ROW_CSR} row_kind_type;

   typedef struct packed {
      logic [GROUP_W-1:0] sender_group;
      logic [USER_W-1:0]  user_id;
      logic [HITS_W-1:0]  hits;
      logic [COUNT_W-1:0] total;
      logic               removed;
   } verdict_type;

   typedef struct {
      row_kind_type           kind;
      logic                   req_type;
      logic [SLOT_W-1:0]      slot;
      logic [POS_W-1:0]       pos;
      logic [BYTE_W-1:0]      data;
      logic                   last;
      logic [GROUP_W-1:0]     sender_group;
      logic [USER_W-1:0]      user_id;
      logic [REG_INDEX_W-1:0] reg_index;
      logic [CSR_DATA_W-1:0]  reg_data;
      logic                   typed;
      verdict_type            verdict;
   } row_type;

   logic clock;
   logic reset;

   kvc_req_if req_bus ();
   kvc_rsp_if rsp_bus ();
   kvc_csr_if csr_bus ();

   keyword_violation_counter_top i_dut (
      .clock(clock),
      .reset(reset),
      .req  (req_bus),
      .rsp  (rsp_bus),
      .csr  (csr_bus)
   );

   // Shadow state of the block.
   logic [BYTE_W-1:0]  kw_byte [MAX_KEYWORDS][MAX_KEYWORD_LEN];
   logic [LEN_W-1:0]   kw_len [MAX_KEYWORDS];
   logic [BYTE_W-1:0]  window [MAX_KEYWORD_LEN];
   int                 msg_seen;
   logic               msg_stopped;
   logic               kw_hit [MAX_KEYWORDS];
   logic [COUNT_W-1:0] tally [COUNTER_DEPTH];
   logic [COUNT_W-1:0] limit_reg;
   logic [ACT_W-1:0]   active_reg;

   bit                 kw_written [MAX_KEYWORDS][MAX_KEYWORD_LEN];
   verdict_type        pending_verdicts[$];
   logic               drv_typed;
   verdict_type        drv_verdict;
   int                 errors;
   int                 cycle_count;
   int                 beats_sent;
   row_type            rows[$];

   function automatic logic [BYTE_W-1:0] fold_case(input logic [BYTE_W-1:0] c);
      return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
   endfunction

   function automatic int live_len(input int s);
      for (int i = 0; i < int'(kw_len[s]); i++) begin
         if (kw_byte[s][i] == 8'd0) begin
            return i;
         end
      end
      return int'(kw_len[s]);
   endfunction

   function automatic int live_slots();
      return (int'(active_reg) > MAX_KEYWORDS) ? MAX_KEYWORDS : int'(active_reg);
   endfunction

   function automatic void clear_message_state();
      for (int i = 0; i < MAX_KEYWORD_LEN; i++) window[i] = 8'd0;
      for (int s = 0; s < MAX_KEYWORDS; s++) kw_hit[s] = 1'b0;
      msg_seen    = 0;
      msg_stopped = 1'b0;
   endfunction

   function automatic void scan_byte(input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] win [MAX_KEYWORD_LEN];
      int                len;
      bit                ok;
      if (msg_stopped || msg_seen >= MAX_MSG_LEN) begin
         return;
      end
      if (b == 8'd0) begin
         msg_stopped = 1'b1;
         return;
      end
      msg_seen++;
      win[0] = fold_case(b);
      for (int i = 1; i < MAX_KEYWORD_LEN; i++) win[i] = window[i-1];
      for (int s = 0; s < live_slots(); s++) begin
         len = live_len(s);
         if (len != 0 && len <= msg_seen) begin
            ok = 1;
            for (int i = 0; i < len; i++) begin
               if (fold_case(kw_byte[s][len-1-i]) != win[i]) ok = 0;
            end
            if (ok) kw_hit[s] = 1'b1;
         end
      end
      for (int i = MAX_KEYWORD_LEN - 1; i > 0; i--) window[i] = window[i-1];
      window[0] = win[0];
   endfunction

   // Returns 1 when the beat finishes a message; the verdict goes to v.
   function automatic bit predict_beat(input logic rtype, input logic [SLOT_W-1:0] slot,
                                       input logic [POS_W-1:0] pos,
                                       input logic [BYTE_W-1:0] b, input logic last,
                                       input logic [GROUP_W-1:0] g,
                                       input logic [USER_W-1:0] u, output verdict_type v);
      int                    hits;
      int                    sum;
      logic [CNT_ADDR_W-1:0] idx;
      v = '0;
      if (rtype == REQ_LOAD) begin
         if (pos < MAX_KEYWORD_LEN) begin
            kw_byte[slot][pos] = b;
            if (last) kw_len[slot] = pos + LEN_W'(1);
         end
         return 0;
      end
      scan_byte(b);
      if (!last) begin
         return 0;
      end
      hits = 0;
      for (int s = 0; s < live_slots(); s++) begin
         if (kw_hit[s] || live_len(s) == 0) hits++;
      end
      idx = {g, u};
      sum = int'(tally[idx]) + hits;
      if (sum > 65535) sum = 65535;
      tally[idx] = COUNT_W'(sum);
      v.sender_group = g;
      v.user_id      = u;
      v.hits         = HITS_W'((hits > 127) ? 127 : hits);
      v.total        = COUNT_W'(sum);
      v.removed      = (COUNT_W'(sum) >= limit_reg);
      clear_message_state();
      return 1;
   endfunction

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      for (int s = 0; s < MAX_KEYWORDS; s++) begin
         kw_len[s] = '0;
         for (int i = 0; i < MAX_KEYWORD_LEN; i++) begin
            kw_byte[s][i]    = '0;
            kw_written[s][i] = 0;
         end
      end
      for (int i = 0; i < COUNTER_DEPTH; i++) tally[i] = '0;
      clear_message_state();
      limit_reg  = 16'd1;
      active_reg = '0;
   end

   // Scoreboard.
   always @(posedge clock) begin
      verdict_type v;
      verdict_type want;
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
      if (!reset) begin
         if (csr_bus.valid && csr_bus.ready) begin
            if (csr_bus.index == REG_VIOLATION_LIMIT) limit_reg = csr_bus.data;
            else if (csr_bus.index == REG_ACTIVE_PATTERNS) active_reg = csr_bus.data[ACT_W-1:0];
         end
         if (req_bus.valid && req_bus.ready) begin
            if (predict_beat(req_bus.req_type, req_bus.pattern_slot, req_bus.pattern_pos,
                             req_bus.data_byte, req_bus.last_byte, req_bus.sender_group,
                             req_bus.user_id, v)) begin
               pending_verdicts.push_back(drv_typed ? drv_verdict : v);
            end
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_verdicts.size() == 0) begin
               $display("%0t: unexpected result beat group %0d user %0d", $time,
                        rsp_bus.out_group, rsp_bus.out_user);
               errors++;
            end else begin
               want = pending_verdicts.pop_front();
               if (rsp_bus.out_group !== want.sender_group) begin
                  $display("%0t: out_group expected %0d actual %0d", $time, want.sender_group,
                           rsp_bus.out_group);
                  errors++;
               end
               if (rsp_bus.out_user !== want.user_id) begin
                  $display("%0t: out_user expected %0d actual %0d", $time, want.user_id,
                           rsp_bus.out_user);
                  errors++;
               end
               if (rsp_bus.message_hits !== want.hits) begin
                  $display("%0t: message_hits expected %0d actual %0d", $time, want.hits,
                           rsp_bus.message_hits);
                  errors++;
               end
               if (rsp_bus.violation_total !== want.total) begin
                  $display("%0t: violation_total expected %0d actual %0d", $time,
                           want.total, rsp_bus.violation_total);
                  errors++;
               end
               if (rsp_bus.removed !== want.removed) begin
                  $display("%0t: removed expected %0d actual %0d", $time, want.removed,
                           rsp_bus.removed);
                  errors++;
               end
            end
         end
      end
   end

   // Result side back-pressure, with one long hold once the block is running.
   initial begin
      int hold;
      int run;
      bit long_done;
      long_done = 0;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (!long_done && cycle_count > 3000) begin
            hold      = 2500;
            long_done = 1;
         end else begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3: hold = 0;
               4, 5, 6, 7, 8: hold = $urandom_range(1, 3);
               default: hold = $urandom_range(10, 40);
            endcase
         end
         if (hold > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         run = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
         repeat (run) @(posedge clock);
      end
   end

   task automatic send_beat(input logic rtype, input logic [SLOT_W-1:0] slot,
                            input logic [POS_W-1:0] pos, input logic [BYTE_W-1:0] b,
                            input logic last, input logic [GROUP_W-1:0] g,
                            input logic [USER_W-1:0] u, input logic typed,
                            input verdict_type v);
      int gap;
      req_bus.req_type     <= rtype;
      req_bus.pattern_slot <= slot;
      req_bus.pattern_pos  <= pos;
      req_bus.data_byte    <= b;
      req_bus.last_byte    <= last;
      req_bus.sender_group <= g;
      req_bus.user_id      <= u;
      drv_typed            <= typed;
      drv_verdict          <= v;
      req_bus.valid        <= 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      beats_sent++;
      case ($urandom_range(0, 19))
         0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: gap = 0;
         19: gap = $urandom_range(10, 40);
         default: gap = $urandom_range(1, 3);
      endcase
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   task automatic write_reg(input logic [REG_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      csr_bus.valid <= 1'b1;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_keyword(input int slot, input int len);
      logic [BYTE_W-1:0] b;
      for (int p = 0; p < len; p++) begin
         if ($urandom_range(0, 29) == 0) b = 8'd0;
         else if ($urandom_range(0, 1)) b = BYTE_W'($urandom_range("A", "F"));
         else b = BYTE_W'($urandom_range("a", "f"));
         kw_written[slot][p] = 1;
         send_beat(REQ_LOAD, SLOT_W'(slot), POS_W'(p), b, p == len - 1, GROUP_W'($urandom),
                   USER_W'($urandom), 1'b0, '0);
      end
   endtask

   task automatic send_message(input int len, input logic [GROUP_W-1:0] g,
                               input logic [USER_W-1:0] u);
      logic [BYTE_W-1:0] b;
      int                i;
      int                s;
      int                klen;
      i = 0;
      while (i < len) begin
         if ($urandom_range(0, 3) == 0 && i + MAX_KEYWORD_LEN < len) begin
            s    = $urandom_range(0, MAX_KEYWORDS - 1);
            klen = int'(kw_len[s]);
            for (int k = 0; k < klen; k++) begin
               b = kw_byte[s][k];
               if ($urandom_range(0, 1) && b >= "a" && b <= "z") b = b - 8'd32;
               send_beat(REQ_MESSAGE, SLOT_W'($urandom), POS_W'($urandom), b, 1'b0, g, u,
                         1'b0, '0);
               i++;
            end
         end else begin
            case ($urandom_range(0, 39))
               0: b = 8'd0;
               1, 2, 3: b = BYTE_W'($urandom);
               default: b = $urandom_range(0, 1) ? BYTE_W'($urandom_range("A", "F"))
                                                 : BYTE_W'($urandom_range("a", "f"));
            endcase
            send_beat(REQ_MESSAGE, SLOT_W'($urandom), POS_W'($urandom), b, i == len - 1, g, u,
                      1'b0, '0);
            i++;
         end
      end
   endtask

   function automatic void add_beat(input logic rtype, input int slot, input int pos,
                                    input int b, input logic last, input int g, input int u);
      row_type r;
      r = '{kind: ROW_BEAT, default: '0};
      r.req_type = rtype; r.slot = SLOT_W'(slot); r.pos = POS_W'(pos);
      r.data = BYTE_W'(b); r.last = last; r.sender_group = GROUP_W'(g);
      r.user_id = USER_W'(u);
      rows.push_back(r);
   endfunction

   function automatic void add_typed(input int b, input int g, input int u, input int hits,
                                     input int total, input logic removed);
      row_type r;
      r = '{kind: ROW_BEAT, default: '0};
      r.req_type = REQ_MESSAGE; r.data = BYTE_W'(b); r.last = 1'b1;
      r.sender_group = GROUP_W'(g); r.user_id = USER_W'(u); r.typed = 1'b1;
      r.verdict = '{GROUP_W'(g), USER_W'(u), HITS_W'(hits), COUNT_W'(total), removed};
      rows.push_back(r);
   endfunction

   function automatic void add_csr(input logic [REG_INDEX_W-1:0] idx, input int value);
      row_type r;
      r = '{kind: ROW_CSR, default: '0};
      r.reg_index = idx; r.reg_data = CSR_DATA_W'(value);
      rows.push_back(r);
   endfunction

   initial begin
      int               slot;
      int               pos;
      int               len;
      logic [GROUP_W-1:0] g;
      logic [USER_W-1:0]  u;
      bit               ok;
      errors       = 0;
      cycle_count  = 0;
      beats_sent   = 0;
      reset        <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.req_type <= 1'b0;
      req_bus.pattern_slot <= '0;
      req_bus.pattern_pos <= '0;
      req_bus.data_byte <= '0;
      req_bus.last_byte <= 1'b0;
      req_bus.sender_group <= '0;
      req_bus.user_id <= '0;
      csr_bus.valid <= 1'b0;
      csr_bus.index <= '0;
      csr_bus.data  <= '0;
      drv_typed     <= 1'b0;
      drv_verdict   <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      add_typed("A", 0, 0, 0, 0, 1'b0);
      add_typed(8'h00, 31, 63, 0, 0, 1'b0);
      add_typed(8'hFF, 5, 7, 0, 0, 1'b0);
      add_csr(REG_ACTIVE_PATTERNS, 64);
      add_csr(REG_VIOLATION_LIMIT, 65535);
      add_typed("x", 1, 1, 64, 64, 1'b0);
      add_beat(REQ_LOAD, 0, 0, "A", 1'b0, 0, 0);
      add_beat(REQ_LOAD, 0, 1, "b", 1'b1, 0, 0);
      add_beat(REQ_LOAD, 1, 0, "Z", 1'b1, 0, 0);
      add_beat(REQ_LOAD, 2, 0, 8'h00, 1'b1, 0, 0);
      add_beat(REQ_LOAD, 63, 31, "q", 1'b1, 0, 0);
      add_csr(REG_ACTIVE_PATTERNS, 4);
      add_csr(REG_VIOLATION_LIMIT, 2);
      add_beat(REQ_MESSAGE, 0, 0, "x", 1'b0, 3, 9);
      add_beat(REQ_MESSAGE, 0, 0, "a", 1'b0, 3, 9);
      add_beat(REQ_MESSAGE, 0, 0, "B", 1'b0, 3, 9);
      add_beat(REQ_MESSAGE, 0, 0, "z", 1'b1, 3, 9);
      add_beat(REQ_MESSAGE, 0, 0, "a", 1'b0, 3, 9);
      add_beat(REQ_MESSAGE, 0, 0, 8'h00, 1'b0, 3, 9);
      add_beat(REQ_MESSAGE, 0, 0, "b", 1'b1, 3, 9);
      add_beat(REQ_MESSAGE, 0, 0, "z", 1'b1, 31, 63);
      add_csr(REG_ACTIVE_PATTERNS, 100);
      add_beat(REQ_MESSAGE, 0, 0, "Z", 1'b1, 31, 63);

      foreach (rows[i]) begin
         if (rows[i].kind == ROW_CSR) begin
            wait_idle();
            write_reg(rows[i].reg_index, rows[i].reg_data);
         end else begin
            send_beat(rows[i].req_type, rows[i].slot, rows[i].pos, rows[i].data,
                      rows[i].last, rows[i].sender_group, rows[i].user_id, rows[i].typed,
                      rows[i].verdict);
         end
      end
      kw_written[0][0] = 1; kw_written[0][1] = 1; kw_written[1][0] = 1;
      kw_written[2][0] = 1;
      send_beat(REQ_LOAD, 0, 0, 0, 1'b0, 0, 0, 1'b0, '0);

      for (int phase = 0; beats_sent < RANDOM_BEATS; phase++) begin
         wait_idle();
         case (phase % 5)
            0: write_reg(REG_VIOLATION_LIMIT, 0);
            1: write_reg(REG_VIOLATION_LIMIT, 65535);
            2: write_reg(REG_VIOLATION_LIMIT, 1);
            default: write_reg(REG_VIOLATION_LIMIT, CSR_DATA_W'($urandom_range(2, 300)));
         endcase
         case (phase % 4)
            0: write_reg(REG_ACTIVE_PATTERNS, 64);
            1: write_reg(REG_ACTIVE_PATTERNS, 127);
            2: write_reg(REG_ACTIVE_PATTERNS, 0);
            default: write_reg(REG_ACTIVE_PATTERNS, CSR_DATA_W'($urandom_range(1, 64)));
         endcase
         repeat (10) begin
            g = ($urandom_range(0, 3) == 0) ? GROUP_W'($urandom)
                                            : GROUP_W'($urandom_range(0, 1));
            u = ($urandom_range(0, 3) == 0) ? USER_W'($urandom)
                                            : USER_W'($urandom_range(0, 2));
            case ($urandom_range(0, 9))
               0, 1: load_keyword($urandom_range(0, MAX_KEYWORDS - 1),
                                  $urandom_range(1, MAX_KEYWORD_LEN));
               2: begin
                  // Stray load beats: out-of-range positions or rewrites of known bytes.
                  slot = $urandom_range(0, MAX_KEYWORDS - 1);
                  if ($urandom_range(0, 1)) begin
                     send_beat(REQ_LOAD, SLOT_W'(slot),
                               POS_W'($urandom_range(MAX_KEYWORD_LEN, 31)),
                               BYTE_W'($urandom), 1'($urandom), g, u, 1'b0, '0);
                  end else begin
                     pos = $urandom_range(0, MAX_KEYWORD_LEN - 1);
                     ok  = 1;
                     for (int k = 0; k <= pos; k++) if (!kw_written[slot][k]) ok = 0;
                     if (ok) send_beat(REQ_LOAD, SLOT_W'(slot), POS_W'(pos),
                                       BYTE_W'($urandom_range("a", "f")), 1'($urandom),
                                       g, u, 1'b0, '0);
                  end
               end
               default: begin
                  if ($urandom_range(0, 29) == 0) len = $urandom_range(250, 280);
                  else len = $urandom_range(1, 12);
                  send_message(len, g, u);
               end
            endcase
         end
      end

      wait_idle();
      repeat (SETTLE_WAIT) @(posedge clock);
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
